FILE: sv/brf_pkg.sv
// brf_pkg: sizes, opcodes and request/response payload types of the byte ring fifo
// no dependencies; imported by byte_ring_fifo_unit, brf_checker, brf_scoreboard and byte_ring_fifo_unit_test

package brf_pkg;

   localparam int unsigned SLOTS  = 4096;
   localparam int unsigned PTR_W  = (SLOTS > 2) ? $clog2(SLOTS) : 1;
   localparam int unsigned CNT_W  = 12;
   localparam int unsigned DISC_W = 16;
   localparam int unsigned WIDE_W = ((PTR_W > DISC_W) ? PTR_W : DISC_W) + 1;

   localparam logic [1:0] OP_PUSH    = 2'd0;
   localparam logic [1:0] OP_PULL    = 2'd1;
   localparam logic [1:0] OP_DISCARD = 2'd2;
   localparam logic [1:0] OP_FLUSH   = 2'd3;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [7:0]        data_byte;
      logic [DISC_W-1:0] discard_count;
      logic              burst_last;
   } req_type;

   typedef struct packed {
      logic [7:0]       read_data;
      logic             done_res;
      logic [CNT_W-1:0] moved_count;
      logic [CNT_W-1:0] fill_level;
      logic [CNT_W-1:0] free_space;
      logic             is_empty;
      logic             is_full;
      logic             burst_end;
   } rsp_type;

endpackage

FILE: sv/byte_ring_fifo_unit.sv
// byte_ring_fifo_unit: byte ring buffer with head/tail pointers, one slot kept empty
// depends on brf_pkg; byte storage is a local synchronous ram with registered read
//
//   channel   ports                          direction   moves
//   request   req_valid req_stall req_data   in          push, pull, discard, flush
//   response  rsp_valid rsp_stall rsp_data   out         one response per request
//
// one request per cycle while req_stall is low; its response shows in the cycle after acceptance
// the pull byte comes from the ram read port, registered in the cycle after the address
// pointers update at acceptance, so the next request sees them at once
// a stalled response holds the single output stage and stalls the request side
// synchronous reset clears the pointers and the output valid; the output data and the ram are not cleared

module byte_ring_fifo_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  brf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output brf_pkg::rsp_type rsp_data
);
   import brf_pkg::*;

   localparam logic [WIDE_W-1:0] SLOTS_WIDE = WIDE_W'(SLOTS);
   localparam logic [PTR_W-1:0]  LAST_SLOT  = PTR_W'(SLOTS - 1);

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] fill_of(input logic [PTR_W-1:0] h,
                                                 input logic [PTR_W-1:0] t);
      logic [WIDE_W-1:0] d;
      d = WIDE_W'(t) + SLOTS_WIDE - WIDE_W'(h);
      if (d >= SLOTS_WIDE) begin
         d = d - SLOTS_WIDE;
      end
      return PTR_W'(d);
   endfunction

   logic [7:0] mem [SLOTS];

   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic             out_valid_ff;
   rsp_type          out_ff, out_in;
   logic             pull_ok_ff, pull_ok_in;
   logic [7:0]       rd_data_ff;

   logic             accept;
   logic             wr_en, rd_en;
   logic [PTR_W-1:0] fill_now, fill_nx, free_nx;
   logic [WIDE_W-1:0] count_w, fill_w, head_sum;

   assign req_stall = out_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      fill_now   = fill_of(head_ff, tail_ff);
      count_w    = WIDE_W'(req_data.discard_count);
      fill_w     = WIDE_W'(fill_now);
      head_sum   = WIDE_W'(head_ff) + count_w;
      if (head_sum >= SLOTS_WIDE) begin
         head_sum = head_sum - SLOTS_WIDE;
      end
      head_in    = head_ff;
      tail_in    = tail_ff;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      pull_ok_in = 1'b0;
      out_in     = '0;
      unique case (req_data.opcode)
         OP_PUSH: begin
            // full when the slot after tail is head
            if (wrap_inc(tail_ff) != head_ff) begin
               wr_en           = accept;
               tail_in         = wrap_inc(tail_ff);
               out_in.done_res = 1'b1;
            end
         end
         OP_PULL: begin
            if (fill_now != '0) begin
               rd_en           = accept;
               head_in         = wrap_inc(head_ff);
               pull_ok_in      = 1'b1;
               out_in.done_res = 1'b1;
            end
         end
         OP_DISCARD: begin
            if (count_w != '0) begin
               if (fill_w >= count_w) begin
                  head_in            = PTR_W'(head_sum);
                  out_in.moved_count = CNT_W'(count_w);
               end else begin
                  // overrun empties the buffer and reports what was held
                  head_in            = '0;
                  tail_in            = '0;
                  out_in.moved_count = CNT_W'(fill_w);
               end
            end
         end
         OP_FLUSH: begin
            head_in = '0;
            tail_in = '0;
         end
         default: begin
            head_in = head_ff;
         end
      endcase
      fill_nx            = fill_of(head_in, tail_in);
      free_nx            = LAST_SLOT - fill_nx;
      out_in.fill_level  = CNT_W'(WIDE_W'(fill_nx));
      out_in.free_space  = CNT_W'(WIDE_W'(free_nx));
      out_in.is_empty    = (head_in == tail_in);
      out_in.is_full     = (wrap_inc(tail_in) == head_in);
      out_in.burst_end   = req_data.burst_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
         end
         if (accept) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_ff     <= out_in;
         pull_ok_ff <= pull_ok_in;
      end
   end

   // byte ram: write at tail on a push, read at head on a pull
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= req_data.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   always_comb begin
      rsp_data           = out_ff;
      rsp_data.read_data = pull_ok_ff ? rd_data_ff : 8'd0;
   end

   assign rsp_valid = out_valid_ff;

endmodule

FILE: sv/brf_checker.sv
// brf_checker: port-level assertions for byte_ring_fifo_unit
// depends on brf_pkg; attached to byte_ring_fifo_unit by the bind below

module brf_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input brf_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input brf_pkg::rsp_type rsp_data
);
   import brf_pkg::*;

   localparam logic [CNT_W:0] LAST_FILL = (CNT_W + 1)'(SLOTS - 1);

   // a request taken now shows its response next cycle
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("response missing after accepted request");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

   a_level_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (({1'b0, rsp_data.fill_level} + {1'b0, rsp_data.free_space})
                     == LAST_FILL))
      else $error("fill plus free does not match capacity");

   a_empty_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!(rsp_data.is_empty && rsp_data.is_full) &&
                     (rsp_data.is_empty == (rsp_data.fill_level == '0))))
      else $error("empty or full flag inconsistent with fill level");

   a_pull_only_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.done_res) |-> (rsp_data.read_data == 8'd0))
      else $error("read data without a delivered pull");

endmodule

bind byte_ring_fifo_unit brf_checker u_brf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: dv/brf_checker.sv
// brf_scoreboard: watches the request and response channels of byte_ring_fifo_unit,
// predicts each response from its own copy of the ring and compares field by field
// depends on brf_pkg
`timescale 1ns / 1ps

module brf_scoreboard (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  brf_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  brf_pkg::rsp_type rsp_data,
   output int               fault_total,
   output int               pending_total
);
   import brf_pkg::*;

   logic [7:0]  ring_bytes [SLOTS];
   int unsigned head_ptr = 0;
   int unsigned tail_ptr = 0;
   rsp_type     expected_rsp [$];
   rsp_type     want;
   int          faults = 0;

   function automatic int unsigned held_bytes();
      return (tail_ptr + SLOTS - head_ptr) % SLOTS;
   endfunction

   function automatic int unsigned room_bytes();
      return (SLOTS + head_ptr - tail_ptr - 1) % SLOTS;
   endfunction

   // applies one request to the shadow ring and returns the response it should produce
   function automatic rsp_type advance_ring(input req_type r);
      rsp_type     o;
      int unsigned level;
      o = '0;
      case (r.opcode)
         OP_PUSH: begin
            if (room_bytes() != 0) begin
               ring_bytes[PTR_W'(tail_ptr)] = r.data_byte;
               tail_ptr = (tail_ptr + 1) % SLOTS;
               o.done_res = 1'b1;
            end
         end
         OP_PULL: begin
            if (held_bytes() != 0) begin
               o.read_data = ring_bytes[PTR_W'(head_ptr)];
               head_ptr = (head_ptr + 1) % SLOTS;
               o.done_res = 1'b1;
            end
         end
         OP_DISCARD: begin
            if (r.discard_count != 0) begin
               level = held_bytes();
               if (level >= r.discard_count) begin
                  head_ptr = (head_ptr + r.discard_count) % SLOTS;
                  o.moved_count = CNT_W'(r.discard_count);
               end else begin
                  // asking for more than is held empties the ring
                  head_ptr = 0;
                  tail_ptr = 0;
                  o.moved_count = CNT_W'(level);
               end
            end
         end
         OP_FLUSH: begin
            head_ptr = 0;
            tail_ptr = 0;
         end
      endcase
      o.fill_level = CNT_W'(held_bytes());
      o.free_space = CNT_W'(room_bytes());
      o.is_empty   = (head_ptr == tail_ptr);
      o.is_full    = (((tail_ptr + 1) % SLOTS) == head_ptr);
      o.burst_end  = r.burst_last;
      return o;
   endfunction

   task automatic report_fault(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      faults++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] exp_val);
      if (got !== exp_val)
         report_fault($sformatf("%s got 0x%0h expected 0x%0h", name, got, exp_val));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         head_ptr = 0;
         tail_ptr = 0;
         expected_rsp.delete();
      end else begin
         // a response never shows in the cycle its request is taken, so check before predicting
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report_fault("response with no request waiting");
            end else begin
               want = expected_rsp.pop_front();
               check_field("read_data", 16'(rsp_data.read_data), 16'(want.read_data));
               check_field("done_res", 16'(rsp_data.done_res), 16'(want.done_res));
               check_field("moved_count", 16'(rsp_data.moved_count),
                           16'(want.moved_count));
               check_field("fill_level", 16'(rsp_data.fill_level), 16'(want.fill_level));
               check_field("free_space", 16'(rsp_data.free_space), 16'(want.free_space));
               check_field("is_empty", 16'(rsp_data.is_empty), 16'(want.is_empty));
               check_field("is_full", 16'(rsp_data.is_full), 16'(want.is_full));
               check_field("burst_end", 16'(rsp_data.burst_end), 16'(want.burst_end));
            end
         end
         if (req_valid && !req_stall)
            expected_rsp.push_back(advance_ring(req_data));
      end
      fault_total   <= faults;
      pending_total <= expected_rsp.size();
   end

endmodule

FILE: dv/byte_ring_fifo_unit_test.sv
// byte_ring_fifo_unit_test: drives push, pull, discard and flush requests into
// byte_ring_fifo_unit with random idling and gives the verdict
// depends on brf_pkg, byte_ring_fifo_unit and brf_scoreboard
`timescale 1ns / 1ps

module byte_ring_fifo_unit_test;
   import brf_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 250;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    rsp_stall = 1'b0;
   req_type req_data  = '0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   int fault_total;
   int pending_total;
   int send_idle_pct = 22;
   int recv_idle_pct = 61;
   int sent_count    = 0;
   int cycle_count   = 0;
   int rsp_seen      = 0;
   int hold_left     = 0;
   int hold_idx      = 0;
   int hold_at [2]   = '{200, 1400};

   byte_ring_fifo_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   brf_scoreboard u_scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fault_total   (fault_total),
      .pending_total (pending_total)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL byte_ring_fifo_unit");
         $finish;
      end
   end

   // response side: random stalls, plus long hold-offs so the block backs up
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         rsp_seen++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_idx < 2 && rsp_seen >= hold_at[hold_idx]) begin
         hold_left = HOLD_CYCLES;
         hold_idx++;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   task automatic offer_request(input logic [1:0] op, input logic [7:0] value,
                                input logic [15:0] count, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{opcode: op, data_byte: value, discard_count: count, burst_last: last};
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   task automatic push_burst(input int len);
      for (int i = 0; i < len; i++)
         offer_request(OP_PUSH, 8'($urandom), 16'($urandom), i == len - 1);
   endtask

   task automatic pull_burst(input int len);
      for (int i = 0; i < len; i++)
         offer_request(OP_PULL, 8'($urandom), 16'($urandom), i == len - 1);
   endtask

   task automatic random_traffic(input int stop_at);
      int pick;
      while (sent_count < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)
            push_burst($urandom_range(1, 24));
         else if (pick < 75)
            pull_burst($urandom_range(1, 24));
         else if (pick < 85)
            offer_request(OP_DISCARD, 8'($urandom), 16'($urandom_range(1, 32)),
                          1'($urandom));
         else if (pick < 90)
            offer_request(OP_DISCARD, 8'($urandom), 16'($urandom), 1'($urandom));
         else if (pick < 92)
            offer_request(OP_FLUSH, 8'($urandom), 16'($urandom), 1'($urandom));
         else
            offer_request(2'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty-ring corner cases first
      offer_request(OP_PULL,    8'h00, 16'h0000, 1'b0);
      offer_request(OP_DISCARD, 8'h00, 16'h0000, 1'b1);
      offer_request(OP_DISCARD, 8'hFF, 16'h0005, 1'b0);
      offer_request(OP_FLUSH,   8'h00, 16'hFFFF, 1'b1);
      offer_request(OP_PUSH,    8'h00, 16'h0000, 1'b0);
      offer_request(OP_PUSH,    8'hFF, 16'hFFFF, 1'b1);
      offer_request(OP_PUSH,    8'hA5, 16'h0000, 1'b0);
      offer_request(OP_PULL,    8'h00, 16'h0000, 1'b0);
      offer_request(OP_DISCARD, 8'h00, 16'h0001, 1'b0);
      // discard of exactly the fill level
      offer_request(OP_DISCARD, 8'h00, 16'h0001, 1'b1);
      offer_request(OP_PULL,    8'h00, 16'h0000, 1'b1);
      offer_request(OP_PUSH,    8'h5A, 16'h0000, 1'b0);
      offer_request(OP_PUSH,    8'h3C, 16'h0000, 1'b0);
      offer_request(OP_PUSH,    8'hC3, 16'h0000, 1'b1);
      offer_request(OP_DISCARD, 8'h00, 16'hFFFF, 1'b0);
      offer_request(OP_PUSH,    8'h81, 16'h0000, 1'b0);
      offer_request(OP_PUSH,    8'h7E, 16'h0000, 1'b1);
      offer_request(OP_FLUSH,   8'hFF, 16'h0000, 1'b0);
      offer_request(OP_PUSH,    8'h01, 16'h0000, 1'b0);
      offer_request(OP_PULL,    8'h00, 16'h0000, 1'b1);
      offer_request(OP_PUSH,    8'h10, 16'h0000, 1'b0);
      offer_request(OP_DISCARD, 8'h00, 16'h0000, 1'b0);
      offer_request(OP_PULL,    8'h00, 16'h0000, 1'b0);
      offer_request(OP_DISCARD, 8'h00, 16'h8000, 1'b1);

      random_traffic(640);
      send_idle_pct = 61;
      recv_idle_pct = 22;
      random_traffic(1280);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_traffic(1900);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_total != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (fault_total == 0)
         $display("PASS byte_ring_fifo_unit");
      else
         $display("FAIL byte_ring_fifo_unit");
      $finish;
   end

endmodule
